>>> src/gradient_stop_color_interpolator_defines.svh
// assertion macros for the gradient stop color interpolator
// included by modules that carry assertions; no other dependencies
`ifndef GRADIENT_STOP_COLOR_INTERPOLATOR_DEFINES_SVH
`define GRADIENT_STOP_COLOR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define GSCI_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gsci: assertion failed");
// condition must never be true outside reset
`define GSCI_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gsci: forbidden condition seen");
`else
`define GSCI_ASSERT(name, clk, rst_n, prop)
`define GSCI_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> src/gsci_pkg.sv
// shared types and constants of the gradient stop color interpolator
// no dependencies; used by gsci_div and the top level
`timescale 1ns / 1ps

package gsci_pkg;

  // restoring division steps for a 17-bit q16 weight
  localparam int DIV_STEPS = 17;

  // command codes of an input item
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } color_t;

  typedef struct packed {
    logic [15:0] pos;
    color_t      color;
  } stop_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } gsci_state_e;

  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

  // pick one channel, red first
  function automatic logic [15:0] chan_sel(color_t c, logic [1:0] ch);
    logic [15:0] v;
    case (ch)
      2'd0:    v = c.red;
      2'd1:    v = c.green;
      2'd2:    v = c.blue;
      default: v = c.alpha;
    endcase
    return v;
  endfunction

endpackage

>>> src/gradient_stop_color_interpolator.sv
// top level of the gradient stop color interpolator: stop table, scan sequencer, blend unit
// depends on gsci_pkg, gsci_div and the assertion macro header
//
// usage
//   command channel: an item transfers at a rising edge with start high and busy low.
//   command_i = 0 loads position_i and in_*_i into table slot stop_index_i (slots at or
//   beyond MAX_STOPS are dropped); a load leaves busy low and yields no result.
//   command_i = 1 evaluates the gradient at t = position_i and yields one result.
//   result channel: valid_o is high for exactly one cycle with out_*_o; the receiver
//   cannot stall, so the result is taken in that cycle; a new command may transfer then.
//   config: cfg_we_i writes stop_count (cfg_wdata_i) at the edge; write only while idle.
// sequence of an evaluate, from the transfer edge to the valid_o cycle
//   t at or below the first stop gives its color; t at or above the last stop gives its color
//   interior t: the end stops are read, then a scan up to slot j (j = upper slot of the
//   bracketing pair, one table read a cycle), then the shared divider (17 quotient bits
//   and the handoff), then blending (one multiply and one add per channel); a zero-width,
//   reversed or unsorted pair returns a stop color without the divide. The single table
//   read port and the bit-serial divider set how long it runs. busy is high throughout.
// reset: state machine idle, stop_count = 1, no result pending; the stop table is not
//   cleared and every slot in use must be loaded before it is evaluated.
`timescale 1ns / 1ps
`include "gradient_stop_color_interpolator_defines.svh"

module gradient_stop_color_interpolator
  import gsci_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [3:0]  stop_index_i,
  input  logic [15:0] position_i,
  input  logic [15:0] in_red_i,
  input  logic [15:0] in_green_i,
  input  logic [15:0] in_blue_i,
  input  logic [15:0] in_alpha_i,
  // config port
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // result channel
  output logic        valid_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_alpha_o
);

  // slot index width and a width that holds both stop_count and MAX_STOPS
  localparam int IW = $clog2(MAX_STOPS);
  localparam int NW = (IW + 1 > 5) ? IW + 1 : 5;

  gsci_state_e state_q, state_d;

  logic [4:0]    cnt_q;            // stop_count register
  logic [15:0]   t_q, t_d;
  logic [IW-1:0] j_q, j_d;         // upper slot of the pair under test
  stop_entry_t   prev_q, prev_d;   // lower stop of the pair
  stop_entry_t   cur_q, cur_d;     // upper stop once the bracket is found
  logic [16:0]   w_q, w_d;         // q16 weight
  logic [1:0]    ch_q, ch_d;
  logic signed [34:0] prod_q, prod_d;
  color_t        col_q, col_d;
  logic          valid_q, valid_d;

  // stop table
  stop_entry_t   mem_q [MAX_STOPS];
  stop_entry_t   rd_q;
  logic [IW-1:0] rd_addr;
  logic          accept;
  logic          load_we;

  // active stop count, clamped to 1..MAX_STOPS
  logic [NW-1:0] cnt_ext, n_act;
  logic [IW-1:0] last_idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // blend datapath
  logic [15:0]        c0_ch, c1_ch;
  logic signed [16:0] diff;
  logic signed [34:0] sum;

  assign accept  = start && !busy;
  assign load_we = accept && (command_i == CMD_LOAD) &&
                   (NW'(stop_index_i) < NW'(MAX_STOPS));

  always_comb begin
    cnt_ext = NW'(cnt_q);
    if (cnt_ext == '0) begin
      n_act = NW'(1);
    end else if (cnt_ext > NW'(MAX_STOPS)) begin
      n_act = NW'(MAX_STOPS);
    end else begin
      n_act = cnt_ext;
    end
    last_idx = IW'(n_act - NW'(1));
  end

  // table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_q[IW'(stop_index_i)] <= '{pos: position_i,
                                    color: '{red: in_red_i, green: in_green_i,
                                             blue: in_blue_i, alpha: in_alpha_i}};
    end
    rd_q <= mem_q[rd_addr];
  end

  // shared multiply: (c1 - c0) * w for the channel in turn
  assign c0_ch = chan_sel(prev_q.color, ch_q);
  assign c1_ch = chan_sel(cur_q.color, ch_q);
  assign diff  = $signed({1'b0, c1_ch}) - $signed({1'b0, c0_ch});
  // c0 * 65536 + rounding + product, always in 0..65535 after the shift
  assign sum   = $signed({3'b000, c0_ch, 16'h8000}) + prod_q;

  gsci_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    j_d     = j_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    w_d     = w_q;
    ch_d    = ch_q;
    prod_d  = prod_q;
    col_d   = col_q;
    valid_d = 1'b0;
    rd_addr = '0;
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        // slot 0 is read on the transfer edge
        if (accept && (command_i == CMD_EVAL)) begin
          t_d     = position_i;
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        prev_d = rd_q;
        if (t_q <= rd_q.pos) begin
          col_d   = rd_q.color;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_addr = last_idx;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (t_q >= rd_q.pos) begin
          col_d   = rd_q.color;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_addr = IW'(1);
          j_d     = IW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // the last slot always brackets here, since t is below it
        if ((t_q <= rd_q.pos) || (j_q == last_idx)) begin
          cur_d = rd_q;
          if (rd_q.pos <= prev_q.pos) begin
            // zero-width or reversed segment
            col_d   = rd_q.color;
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end else if (t_q <= prev_q.pos) begin
            // unsorted table, weight zero
            col_d   = prev_q.color;
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {1'b0, t_q - prev_q.pos};
            div_req.den   = rd_q.pos - prev_q.pos;
            state_d       = ST_DIV;
          end
        end else begin
          prev_d  = rd_q;
          j_d     = j_q + IW'(1);
          rd_addr = j_q + IW'(1);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          w_d     = div_rsp.quot;
          ch_d    = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = 35'(diff) * 35'($signed({1'b0, w_q}));
        state_d = ST_ACC;
      end
      ST_ACC: begin
        case (ch_q)
          2'd0:    col_d.red   = sum[31:16];
          2'd1:    col_d.green = sum[31:16];
          2'd2:    col_d.blue  = sum[31:16];
          default: col_d.alpha = sum[31:16];
        endcase
        ch_d = ch_q + 2'd1;
        if (ch_q == 2'd3) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= 5'd1;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    j_q    <= j_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    w_q    <= w_d;
    ch_q   <= ch_d;
    prod_q <= prod_d;
    col_q  <= col_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign out_red_o   = col_q.red;
  assign out_green_o = col_q.green;
  assign out_blue_o  = col_q.blue;
  assign out_alpha_o = col_q.alpha;

  `GSCI_ASSERT(a_result_after_eval, clk_i, rst_ni, valid_o |-> $past(busy))
  `GSCI_ASSERT(a_eval_goes_busy, clk_i, rst_ni, (start && !busy && (command_i == CMD_EVAL)) |=> busy)
  `GSCI_ASSERT(a_load_no_result, clk_i, rst_ni, (start && !busy && (command_i == CMD_LOAD)) |=> !valid_o)
  `GSCI_NEVER(a_div_done_outside_wait, clk_i, rst_ni, div_rsp.done && (state_q != ST_DIV))

endmodule

>>> src/gsci_div.sv
// iterative restoring divider: floor((num << 16) / den), one quotient bit a cycle
// depends on gsci_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "gradient_stop_color_interpolator_defines.svh"

module gsci_div
  import gsci_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [16:0] quot_q, quot_d;
  logic        ge;
  logic [16:0] sub;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    ge     = (rem_q >= {1'b0, den_q});
    sub    = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = req_i.num;
      den_d = req_i.den;
    end else if (run_q) begin
      // remainder stays below den, so the shift fits
      rem_d  = {sub[15:0], 1'b0};
      quot_d = {quot_q[15:0], ge};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  `GSCI_NEVER(a_div_restart, clk_i, rst_ni, req_i.start && run_q)
  `GSCI_NEVER(a_div_done_while_run, clk_i, rst_ni, done_q && run_q)
  `GSCI_ASSERT(a_div_done_after_last, clk_i, rst_ni, done_q |-> $past(run_q))

endmodule

>>> verif/testbench.sv
// self-checking testbench for gradient_stop_color_interpolator: stop loads, evaluates, stop_count
// depends on gsci_pkg for the color type and on the rtl of the block; runs on its own
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SLOT_COUNT    = 16;
  localparam int unsigned RANDOM_ITEMS  = 1750;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // settle wait before a stop_count write and at the end of the drain
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned DRAIN_LIMIT   = 2000;

  // stop counts visited first, extremes and out-of-range values among them
  localparam logic [4:0] COUNT_SWEEP [7] = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd17, 5'd1, 5'd3};

  typedef struct packed {
    logic             command;
    logic [3:0]       slot;
    logic [15:0]      pos;
    gsci_pkg::color_t color;
  } cmd_item_t;

  // holds a copy of the stop table and stop_count, predicts each evaluate
  // and checks the colors coming out against the oldest prediction
  class gradient_color_board;
    logic [15:0]      pos_tab [SLOT_COUNT];
    gsci_pkg::color_t color_tab [SLOT_COUNT];
    logic [4:0]       count_reg;
    gsci_pkg::color_t colors_due [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pos_tab[i]   = '0;
        color_tab[i] = '0;
      end
      count_reg = 5'd1;
      errors    = 0;
    endfunction

    // weighted mix of two channels, rounding half up
    static function logic [15:0] blend(logic [15:0] c0, logic [15:0] c1, logic [16:0] w);
      logic [63:0] acc;
      acc = 64'(c0) * (64'd65536 - 64'(w)) + 64'(c1) * 64'(w) + 64'd32768;
      return acc[31:16];
    endfunction

    function gsci_pkg::color_t gradient_color(logic [15:0] t);
      int unsigned      n;
      int unsigned      k;
      logic [63:0]      num;
      logic [63:0]      den;
      logic [16:0]      w;
      gsci_pkg::color_t c0;
      gsci_pkg::color_t c1;
      // zero counts as one stop, anything above the table as a full table
      n = (count_reg == 5'd0) ? 1 : (count_reg > SLOT_COUNT) ? SLOT_COUNT : count_reg;
      if (t <= pos_tab[0]) return color_tab[0];
      if (t >= pos_tab[n-1]) return color_tab[n-1];
      k = 0;
      while (k + 1 < n && t > pos_tab[k+1]) k++;
      c0 = color_tab[k];
      c1 = color_tab[k+1];
      // zero-width or reversed segment gives the upper color
      if (pos_tab[k+1] <= pos_tab[k]) return c1;
      if (t <= pos_tab[k]) begin
        w = '0;
      end else begin
        num = 64'(t - pos_tab[k]) << 16;
        den = 64'(pos_tab[k+1] - pos_tab[k]);
        num = num / den;
        w   = (num > 64'd65536) ? 17'd65536 : num[16:0];
      end
      return {blend(c0.red, c1.red, w), blend(c0.green, c1.green, w),
              blend(c0.blue, c1.blue, w), blend(c0.alpha, c1.alpha, w)};
    endfunction

    function void note_command(cmd_item_t it);
      if (it.command == gsci_pkg::CMD_LOAD) begin
        pos_tab[it.slot]   = it.pos;
        color_tab[it.slot] = it.color;
      end else begin
        colors_due.insert(colors_due.size(), gradient_color(it.pos));
      end
    endfunction

    function void check_color(gsci_pkg::color_t got);
      gsci_pkg::color_t want;
      if (colors_due.size() == 0) begin
        $error("color result with no evaluate outstanding: %h", got);
        errors++;
        return;
      end
      want = colors_due.pop_front();
      if (got.red !== want.red) begin
        $error("out_red: expected %h, got %h", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %h, got %h", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %h, got %h", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("out_alpha: expected %h, got %h", want.alpha, got.alpha);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic        command_i    = gsci_pkg::CMD_LOAD;
  logic [3:0]  stop_index_i = '0;
  logic [15:0] position_i   = '0;
  logic [15:0] in_red_i     = '0;
  logic [15:0] in_green_i   = '0;
  logic [15:0] in_blue_i    = '0;
  logic [15:0] in_alpha_i   = '0;
  logic        cfg_we_i     = 1'b0;
  logic [4:0]  cfg_wdata_i  = '0;
  logic        valid_o;
  logic [15:0] out_red_o;
  logic [15:0] out_green_o;
  logic [15:0] out_blue_o;
  logic [15:0] out_alpha_o;

  gradient_color_board color_board = new();

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;

  gradient_stop_color_interpolator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .stop_index_i (stop_index_i),
    .position_i   (position_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .in_alpha_i   (in_alpha_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_o      (valid_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung block or a lost result ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // results are shown for one cycle only, so every strobe is taken at its edge
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      color_board.check_color({out_red_o, out_green_o, out_blue_o, out_alpha_o});
    end
  end

  // channel values lean toward the rails so the blend sees its extremes often
  function automatic logic [15:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic gsci_pkg::color_t rand_color();
    return {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
  endfunction

  // one command transfer; the sender runs in bursts with random gaps between them
  task automatic send_command(input cmd_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      case ($urandom_range(0, 4))
        0, 1:    gap = 0;
        2, 3:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 50);
      endcase
      if (gap != 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start        = 1'b1;
    command_i    = it.command;
    stop_index_i = it.slot;
    position_i   = it.pos;
    in_red_i     = it.color.red;
    in_green_i   = it.color.green;
    in_blue_i    = it.color.blue;
    in_alpha_i   = it.color.alpha;
    // busy seen at the edge decides whether the transfer happened
    do @(posedge clk_i); while (busy !== 1'b0);
    color_board.note_command(it);
    items_sent++;
  endtask

  task automatic load_stop(input logic [3:0] slot, input logic [15:0] pos,
                           input gsci_pkg::color_t color);
    send_command({gsci_pkg::CMD_LOAD, slot, pos, color});
  endtask

  // slot and color fields are don't-care on an evaluate, so they carry noise
  task automatic eval_at(input logic [15:0] t);
    send_command({gsci_pkg::CMD_EVAL, 4'($urandom), t, rand_color()});
  endtask

  // stop_count changes only with the block idle and every color delivered
  task automatic set_stop_count(input logic [4:0] value);
    @(negedge clk_i);
    start      = 1'b0;
    burst_left = 0;
    while (color_board.colors_due.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    color_board.count_reg = value;
  endtask

  // one setting of stop_count: reload the stops in use, then mostly evaluates
  task automatic run_phase(input logic [4:0] count_val, input int unsigned n_items);
    int unsigned active;
    int unsigned j;
    int          sorted_q [$];
    logic [15:0] plan [SLOT_COUNT];
    logic [15:0] t;
    logic [15:0] lo;
    logic [15:0] hi;
    set_stop_count(count_val);
    active = (count_val == 5'd0) ? 1 : (count_val > SLOT_COUNT) ? SLOT_COUNT : count_val;
    sorted_q = {};
    for (j = 0; j < active; j++) sorted_q.insert(sorted_q.size(), int'($urandom_range(0, 65535)));
    if ($urandom_range(0, 3) == 0) sorted_q[0] = 0;
    if ($urandom_range(0, 3) == 0) sorted_q[active-1] = 65535;
    sorted_q.sort();
    for (j = 0; j < SLOT_COUNT; j++) plan[j] = (j < active) ? 16'(sorted_q[j]) : 16'($urandom);
    // most tables are sorted; some carry repeated, unordered or flat positions
    case ($urandom_range(0, 9))
      6, 7: begin
        for (j = 1; j < active; j++) if ($urandom_range(0, 2) == 0) plan[j] = plan[j-1];
      end
      8: begin
        for (j = 0; j < active; j++) plan[j] = 16'($urandom);
      end
      9: begin
        for (j = 1; j < active; j++) plan[j] = plan[0];
      end
      default: ;
    endcase
    // every slot in use is written before any evaluate reads it
    for (j = 0; j < SLOT_COUNT; j++) begin
      if (j < active || $urandom_range(0, 3) == 0) load_stop(4'(j), plan[j], rand_color());
    end
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        j = $urandom_range(0, SLOT_COUNT - 1);
        if ($urandom_range(0, 1) == 1) plan[j] = 16'($urandom);
        load_stop(4'(j), plan[j], rand_color());
      end else begin
        j = $urandom_range(0, active - 1);
        case ($urandom_range(0, 7))
          0:       t = 16'($urandom);
          1:       t = plan[j];
          2:       t = plan[j] + 16'd1;
          3:       t = plan[j] - 16'd1;
          4:       t = 16'h0000;
          5:       t = 16'hFFFF;
          default: begin
            // somewhere inside a segment
            lo = plan[j];
            hi = plan[(j + 1 < active) ? j + 1 : j];
            if (lo > hi) begin
              t  = lo;
              lo = hi;
              hi = t;
            end
            t = 16'($urandom_range(lo, hi));
          end
        endcase
        eval_at(t);
      end
    end
  endtask

  initial begin
    int unsigned directed_items;
    int unsigned phase_no;
    int unsigned guard;
    logic [4:0]  next_count;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // single stop at reset count: everything returns that color
    load_stop(4'd0, 16'h8000, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    eval_at(16'h0000);
    eval_at(16'h8000);
    eval_at(16'hFFFF);

    // four stops with a zero-width pair in the middle and rail colors
    set_stop_count(5'd4);
    load_stop(4'd0, 16'h1000, '0);
    load_stop(4'd1, 16'h4000, {4{16'hFFFF}});
    load_stop(4'd2, 16'h4000, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
    load_stop(4'd3, 16'hFFFF, {16'hFFFF, 16'h0000, 16'h8000, 16'h0001});
    eval_at(16'h0FFF);
    eval_at(16'h1000);
    eval_at(16'h1001);
    eval_at(16'h2800);
    eval_at(16'h4000);
    eval_at(16'h4001);
    eval_at(16'hFFFE);
    eval_at(16'hFFFF);

    // second stop moved below the first: the table is no longer sorted
    load_stop(4'd1, 16'h0800, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    eval_at(16'h0900);
    eval_at(16'h3000);
    // last stop below the first stop
    load_stop(4'd3, 16'h0400, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    eval_at(16'h2000);
    // highest slot index
    load_stop(4'd15, 16'hFFFF, {4{16'hFFFF}});
    directed_items = items_sent;

    phase_no = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      next_count = (phase_no < 7) ? COUNT_SWEEP[phase_no] : 5'($urandom_range(0, 31));
      run_phase(next_count, $urandom_range(40, 80));
      phase_no++;
    end

    // drain: wait for every color, then for any straggler
    @(negedge clk_i);
    start = 1'b0;
    guard = 0;
    while (color_board.colors_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (color_board.colors_due.size() != 0) begin
      $error("%0d evaluate results never arrived", color_board.colors_due.size());
      color_board.errors++;
    end
    if (color_board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
